// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define SSGO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define SSGO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ssgo_pkg.sv -----
// ----------------------------------------------------------------------------
// ssgo_pkg
// Shared types, constants and the micro-programme of the grid offset smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package ssgo_pkg;

    // Number formats
    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;
    localparam int POS_W     = 48;
    localparam int OFS_W     = 47;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int ACC_W     = 128;
    localparam int LIM_BITS  = 62;
    localparam int CFG_W     = 32;
    localparam int ME_W      = 16;
    localparam int FT_W      = 16;
    localparam int PERIOD_W  = CFG_W + ME_W;
    localparam int DIV_NW    = (2 * FRAC_BITS + 2 > POS_W) ? 2 * FRAC_BITS + 2 : POS_W;
    localparam int DIV_CW    = $clog2(DIV_NW + 1);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [POS_W-1:0]  pos_t;

    localparam word_t ONE_Q  = word_t'(64'sd1 <<< FRAC_BITS);
    localparam word_t LIM    = word_t'((64'sd1 <<< LIM_BITS) - 64'sd1);
    localparam word_t K1     = word_t'((64'sd48 * ONE_Q + 64'sd50) / 64'sd100);
    localparam word_t K2     = word_t'((64'sd235 * ONE_Q + 64'sd500) / 64'sd1000);
    localparam word_t THR2   = word_t'(64'sd1000000 * ONE_Q);
    localparam word_t NUM_OM = word_t'(64'sd1 <<< (2 * FRAC_BITS + 1));
    localparam word_t NUM_E  = word_t'(64'sd1 <<< (2 * FRAC_BITS));
    localparam word_t P_MAX  = word_t'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam word_t P_MIN  = word_t'(-(64'sd1 <<< (POS_W - 1)));

    localparam logic [CFG_W-1:0] MIN_ST = CFG_W'((ONE_Q + 64'sd999) / 64'sd1000);
    localparam logic [CFG_W-1:0] MIN_SP = CFG_W'((ONE_Q + 64'sd9999) / 64'sd10000);
    localparam logic [CFG_W-1:0] RST_ST = CFG_W'((ONE_Q + 64'sd5) / 64'sd10);
    localparam logic [CFG_W-1:0] RST_SP = CFG_W'(ONE_Q);
    localparam logic [ME_W-1:0]  RST_ME = ME_W'(10);

    // Configuration register indexes
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ENABLE = 2'd0;
    localparam reg_idx_t REG_STIME  = 2'd1;
    localparam reg_idx_t REG_SPACE  = 2'd2;
    localparam reg_idx_t REG_MAJOR  = 2'd3;

    // Micro-operations
    typedef logic [2:0] op_t;
    localparam op_t OP_NOP  = 3'd0;
    localparam op_t OP_MUL  = 3'd1;
    localparam op_t OP_DIV  = 3'd2;
    localparam op_t OP_MOD  = 3'd3;
    localparam op_t OP_ADD  = 3'd4;
    localparam op_t OP_SUB  = 3'd5;
    localparam op_t OP_SNAP = 3'd6;
    localparam op_t OP_INIT = 3'd7;

    // Operand sources
    typedef logic [4:0] src_t;
    localparam src_t SRC_OMEGA  = 5'd0;
    localparam src_t SRC_FT     = 5'd1;
    localparam src_t SRC_X      = 5'd2;
    localparam src_t SRC_X2     = 5'd3;
    localparam src_t SRC_X3     = 5'd4;
    localparam src_t SRC_K1     = 5'd5;
    localparam src_t SRC_K2     = 5'd6;
    localparam src_t SRC_ONE    = 5'd7;
    localparam src_t SRC_T1     = 5'd8;
    localparam src_t SRC_T2     = 5'd9;
    localparam src_t SRC_DEN    = 5'd10;
    localparam src_t SRC_E      = 5'd11;
    localparam src_t SRC_CH     = 5'd12;
    localparam src_t SRC_TMP    = 5'd13;
    localparam src_t SRC_T      = 5'd14;
    localparam src_t SRC_VEL    = 5'd15;
    localparam src_t SRC_CAM    = 5'd16;
    localparam src_t SRC_POS    = 5'd17;
    localparam src_t SRC_D2     = 5'd18;
    localparam src_t SRC_NUM_OM = 5'd19;
    localparam src_t SRC_NUM_E  = 5'd20;
    localparam src_t SRC_ST     = 5'd21;
    localparam src_t SRC_PERIOD = 5'd22;
    localparam src_t SRC_POSX   = 5'd23;
    localparam src_t SRC_POSY   = 5'd24;

    // Result destinations
    typedef logic [4:0] dst_t;
    localparam dst_t DST_NONE  = 5'd0;
    localparam dst_t DST_OMEGA = 5'd1;
    localparam dst_t DST_X     = 5'd2;
    localparam dst_t DST_X2    = 5'd3;
    localparam dst_t DST_X3    = 5'd4;
    localparam dst_t DST_T1    = 5'd5;
    localparam dst_t DST_T2    = 5'd6;
    localparam dst_t DST_DEN   = 5'd7;
    localparam dst_t DST_E     = 5'd8;
    localparam dst_t DST_CH    = 5'd9;
    localparam dst_t DST_TMP   = 5'd10;
    localparam dst_t DST_T     = 5'd11;
    localparam dst_t DST_VEL   = 5'd12;
    localparam dst_t DST_POS   = 5'd13;
    localparam dst_t DST_D2    = 5'd14;
    localparam dst_t DST_OX    = 5'd15;
    localparam dst_t DST_OY    = 5'd16;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        dst_t dst;
        logic sh_dt;
    } uop_t;

    typedef logic [4:0] pc_t;
    localparam pc_t PC_AXIS     = 5'd10;
    localparam pc_t PC_AXIS_END = 5'd22;
    localparam pc_t PC_WRAPX    = 5'd24;
    localparam pc_t PC_WRAPY    = 5'd25;
    localparam pc_t PC_INIT     = 5'd26;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_LAST = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic  issue;
        logic  capture;
        logic  publish;
        axis_t axis;
        uop_t  uop;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic enable;
        logic first;
        logic out_free;
    } stat_t;

    function automatic word_t sat_add(input word_t a, input word_t b);
        word_t s;
        s = a + b;
        if (s > LIM)
            return LIM;
        if (s < -LIM)
            return -LIM;
        return s;
    endfunction

    function automatic pos_t clamp_pos(input word_t v);
        word_t c;
        c = (v > P_MAX) ? P_MAX : ((v < P_MIN) ? P_MIN : v);
        return c[POS_W-1:0];
    endfunction

    function automatic uop_t mk(input op_t op, input src_t a, input src_t b,
                                input dst_t dst, input logic sh_dt);
        uop_t u;
        u.op    = op;
        u.a     = a;
        u.b     = b;
        u.dst   = dst;
        u.sh_dt = sh_dt;
        return u;
    endfunction

    // Micro-programme: spring coefficients, per-axis update, snap, wrap, pass-through init
    function automatic uop_t ucode(input pc_t pc);
        uop_t u;
        unique case (pc)
            5'd0:  u = mk(OP_DIV, SRC_NUM_OM, SRC_ST, DST_OMEGA, 1'b0);
            5'd1:  u = mk(OP_MUL, SRC_OMEGA, SRC_FT, DST_X, 1'b1);
            5'd2:  u = mk(OP_MUL, SRC_X, SRC_X, DST_X2, 1'b0);
            5'd3:  u = mk(OP_MUL, SRC_X2, SRC_X, DST_X3, 1'b0);
            5'd4:  u = mk(OP_MUL, SRC_K1, SRC_X2, DST_T1, 1'b0);
            5'd5:  u = mk(OP_MUL, SRC_K2, SRC_X3, DST_T2, 1'b0);
            5'd6:  u = mk(OP_ADD, SRC_ONE, SRC_X, DST_X, 1'b0);
            5'd7:  u = mk(OP_ADD, SRC_T1, SRC_T2, DST_T1, 1'b0);
            5'd8:  u = mk(OP_ADD, SRC_X, SRC_T1, DST_DEN, 1'b0);
            5'd9:  u = mk(OP_DIV, SRC_NUM_E, SRC_DEN, DST_E, 1'b0);
            5'd10: u = mk(OP_SUB, SRC_POS, SRC_CAM, DST_CH, 1'b0);
            5'd11: u = mk(OP_MUL, SRC_OMEGA, SRC_CH, DST_T, 1'b0);
            5'd12: u = mk(OP_ADD, SRC_VEL, SRC_T, DST_T, 1'b0);
            5'd13: u = mk(OP_MUL, SRC_T, SRC_FT, DST_TMP, 1'b1);
            5'd14: u = mk(OP_MUL, SRC_OMEGA, SRC_TMP, DST_T, 1'b0);
            5'd15: u = mk(OP_SUB, SRC_VEL, SRC_T, DST_T, 1'b0);
            5'd16: u = mk(OP_MUL, SRC_T, SRC_E, DST_VEL, 1'b0);
            5'd17: u = mk(OP_ADD, SRC_CH, SRC_TMP, DST_T, 1'b0);
            5'd18: u = mk(OP_MUL, SRC_T, SRC_E, DST_T, 1'b0);
            5'd19: u = mk(OP_ADD, SRC_CAM, SRC_T, DST_POS, 1'b0);
            5'd20: u = mk(OP_SUB, SRC_POS, SRC_CAM, DST_T, 1'b0);
            5'd21: u = mk(OP_MUL, SRC_T, SRC_T, DST_T, 1'b0);
            5'd22: u = mk(OP_ADD, SRC_D2, SRC_T, DST_D2, 1'b0);
            5'd23: u = mk(OP_SNAP, SRC_D2, SRC_D2, DST_NONE, 1'b0);
            5'd24: u = mk(OP_MOD, SRC_POSX, SRC_PERIOD, DST_OX, 1'b0);
            5'd25: u = mk(OP_MOD, SRC_POSY, SRC_PERIOD, DST_OY, 1'b0);
            5'd26: u = mk(OP_INIT, SRC_CAM, SRC_CAM, DST_NONE, 1'b0);
            default: u = mk(OP_NOP, SRC_ONE, SRC_ONE, DST_NONE, 1'b0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssgo_mul.sv -----
// ----------------------------------------------------------------------------
// ssgo_mul
// Signed multiply, shift right and saturate; four 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module ssgo_mul
    import ssgo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire word_t a,
    input  wire word_t b,
    input  wire logic  sh_dt,
    output logic       done,
    output word_t      result
);

    logic                busy_reg;
    logic [2:0]          cnt_reg;
    logic [WORD_W-1:0]   ua_reg;
    logic [WORD_W-1:0]   ub_reg;
    logic                neg_reg;
    logic                sh_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic [HALF_W-1:0]   ha;
    logic [HALF_W-1:0]   hb;
    logic [WORD_W-1:0]   pp;
    logic [1:0]          psum;
    logic [ACC_W-1:0]    shifted;
    word_t               mag;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd4)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    // One partial product per cycle
    assign ha   = cnt_reg[1] ? ua_reg[WORD_W-1:HALF_W] : ua_reg[HALF_W-1:0];
    assign hb   = cnt_reg[0] ? ub_reg[WORD_W-1:HALF_W] : ub_reg[HALF_W-1:0];
    assign pp   = ha * hb;
    assign psum = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
            ub_reg  <= b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
            neg_reg <= a[WORD_W-1] ^ b[WORD_W-1];
            sh_reg  <= sh_dt;
            acc_reg <= '0;
        end
        else if (busy_reg && cnt_reg != 3'd4)
        begin
            acc_reg <= acc_reg + (ACC_W'(pp) << {psum, 5'd0});
        end
    end

    // Shift, saturate, sign
    assign shifted = sh_reg ? (acc_reg >> DT_BITS) : (acc_reg >> FRAC_BITS);
    assign mag     = (|shifted[ACC_W-1:LIM_BITS]) ? LIM
                                                  : word_t'({2'b00, shifted[LIM_BITS-1:0]});
    assign result  = neg_reg ? -mag : mag;
    assign done    = busy_reg && (cnt_reg == 3'd4);

endmodule

`default_nettype wire

// ----- rtl/core/ssgo_div.sv -----
// ----------------------------------------------------------------------------
// ssgo_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssgo_div
    import ssgo_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DIV_NW-1:0]   num,
    input  wire logic [WORD_W-1:0]   den,
    output logic                     done,
    output logic [DIV_NW-1:0]        quot,
    output logic [WORD_W-1:0]        rem
);

    logic                busy_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic [DIV_NW-1:0]   q_reg;
    logic [WORD_W-1:0]   r_reg;
    logic [WORD_W-1:0]   d_reg;

    logic [WORD_W-1:0]   rsh;
    logic                ge;

    assign done = busy_reg && (cnt_reg == DIV_CW'(DIV_NW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (done)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + DIV_CW'(1);
        end
    end

    // Trial subtraction
    assign rsh = {r_reg[WORD_W-2:0], q_reg[DIV_NW-1]};
    assign ge  = (rsh >= d_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg && !done)
        begin
            r_reg <= ge ? rsh - d_reg : rsh;
            q_reg <= {q_reg[DIV_NW-2:0], ge};
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ssgo_dpath.sv -----
// ----------------------------------------------------------------------------
// ssgo_dpath
// Datapath: configuration, spring state, working registers, shared units.
// ----------------------------------------------------------------------------
`default_nettype none

module ssgo_dpath
    import ssgo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire reg_idx_t          cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire pos_t              cam_x,
    input  wire pos_t              cam_y,
    input  wire pos_t              cam_z,
    input  wire logic [FT_W-1:0]   frame_time,
    input  wire logic              out_stall,
    input  wire cmd_t              cmd,
    output stat_t                  stat,
    output logic                   out_valid,
    output logic [OFS_W-1:0]       offset_x,
    output logic [OFS_W-1:0]       offset_y,
    output logic                   snapped
);

    // Configuration
    logic               en_reg;
    logic [CFG_W-1:0]   st_reg;
    logic [CFG_W-1:0]   sp_reg;
    logic [ME_W-1:0]    me_reg;
    logic [CFG_W-1:0]   st_c;
    logic [CFG_W-1:0]   sp_c;
    logic [ME_W-1:0]    me_c;
    logic [PERIOD_W-1:0] period_reg;

    // Spring state
    pos_t  pos_reg [3];
    pos_t  vel_reg [3];
    logic  first_reg;

    // Transaction and working registers
    pos_t              cam_reg [3];
    logic [FT_W-1:0]   ft_reg;
    word_t omega_reg, x_reg, x2_reg, x3_reg, t1_reg, t2_reg, den_reg, e_reg;
    word_t ch_reg, tmp_reg, t_reg, d2_reg;
    logic [OFS_W-1:0]  wx_reg;
    logic [OFS_W-1:0]  wy_reg;
    logic              snap_reg;
    logic              out_valid_reg;
    logic [OFS_W-1:0]  offset_x_reg;
    logic [OFS_W-1:0]  offset_y_reg;
    logic              snapped_reg;

    word_t               opa;
    word_t               opb;
    word_t               opa_abs;
    logic                mul_start;
    logic                mul_done;
    word_t               mul_res;
    logic                div_start;
    logic                div_done;
    logic [DIV_NW-1:0]   div_quot;
    logic [WORD_W-1:0]   div_rem;
    logic [PERIOD_W-1:0] rmod;
    logic [PERIOD_W-1:0] wrapped;
    logic                wr_en;
    word_t               wr_val;
    logic                is_alu;
    logic                far_away;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
            st_reg <= RST_ST;
            sp_reg <= RST_SP;
            me_reg <= RST_ME;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE: en_reg <= cfg_data[0];
                REG_STIME:  st_reg <= cfg_data;
                REG_SPACE:  sp_reg <= cfg_data;
                REG_MAJOR:  me_reg <= cfg_data[ME_W-1:0];
            endcase
        end
    end

    assign st_c = (st_reg < MIN_ST) ? MIN_ST : st_reg;
    assign sp_c = (sp_reg < MIN_SP) ? MIN_SP : sp_reg;
    assign me_c = (me_reg == '0) ? ME_W'(1) : me_reg;

    // Grid period is registered from the clamped configuration
    always_ff @(posedge clk)
    begin
        period_reg <= PERIOD_W'(sp_c) * PERIOD_W'(me_c);
    end

    // Operand selection
    function automatic word_t pick(input src_t s);
        word_t v;
        unique case (s)
            SRC_OMEGA:  v = omega_reg;
            SRC_FT:     v = word_t'(ft_reg);
            SRC_X:      v = x_reg;
            SRC_X2:     v = x2_reg;
            SRC_X3:     v = x3_reg;
            SRC_K1:     v = K1;
            SRC_K2:     v = K2;
            SRC_ONE:    v = ONE_Q;
            SRC_T1:     v = t1_reg;
            SRC_T2:     v = t2_reg;
            SRC_DEN:    v = den_reg;
            SRC_E:      v = e_reg;
            SRC_CH:     v = ch_reg;
            SRC_TMP:    v = tmp_reg;
            SRC_T:      v = t_reg;
            SRC_VEL:    v = word_t'(vel_reg[cmd.axis]);
            SRC_CAM:    v = word_t'(cam_reg[cmd.axis]);
            SRC_POS:    v = word_t'(pos_reg[cmd.axis]);
            SRC_D2:     v = d2_reg;
            SRC_NUM_OM: v = NUM_OM;
            SRC_NUM_E:  v = NUM_E;
            SRC_ST:     v = word_t'(st_c);
            SRC_PERIOD: v = word_t'(period_reg);
            SRC_POSX:   v = word_t'(pos_reg[0]);
            SRC_POSY:   v = word_t'(pos_reg[1]);
            default:    v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa = pick(cmd.uop.a);
        opb = pick(cmd.uop.b);
    end

    assign opa_abs = opa[WORD_W-1] ? -opa : opa;

    // Shared arithmetic units
    assign mul_start = cmd.issue && (cmd.uop.op == OP_MUL);
    assign div_start = cmd.issue && ((cmd.uop.op == OP_DIV) || (cmd.uop.op == OP_MOD));

    ssgo_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (opa),
        .b      (opb),
        .sh_dt  (cmd.uop.sh_dt),
        .done   (mul_done),
        .result (mul_res)
    );

    ssgo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa_abs[DIV_NW-1:0]),
        .den   (opb),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // Floor modulo from the magnitude remainder
    assign rmod    = div_rem[PERIOD_W-1:0];
    assign wrapped = (opa[WORD_W-1] && rmod != '0) ? period_reg - rmod : rmod;

    // Result write-back
    assign is_alu = (cmd.uop.op == OP_ADD) || (cmd.uop.op == OP_SUB);

    always_comb
    begin
        wr_en  = 1'b0;
        wr_val = '0;
        if (cmd.issue && is_alu)
        begin
            wr_en  = 1'b1;
            wr_val = (cmd.uop.op == OP_ADD) ? sat_add(opa, opb) : sat_add(opa, -opb);
        end
        else if (mul_done)
        begin
            wr_en  = 1'b1;
            wr_val = mul_res;
        end
        else if (div_done)
        begin
            wr_en  = 1'b1;
            wr_val = (cmd.uop.op == OP_MOD) ? word_t'(wrapped) : word_t'(div_quot);
        end
    end

    assign far_away = (d2_reg > THR2);

    // Spring state, snap flag and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            first_reg     <= 1'b1;
            snap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
                snap_reg <= 1'b0;
            if (cmd.issue && cmd.uop.op == OP_INIT)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_reg[i] <= cam_reg[i];
                    vel_reg[i] <= '0;
                end
                first_reg <= !en_reg;
            end
            if (cmd.issue && cmd.uop.op == OP_SNAP && far_away)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_reg[i] <= cam_reg[i];
                    vel_reg[i] <= '0;
                end
                snap_reg <= 1'b1;
            end
            if (wr_en && cmd.uop.dst == DST_VEL)
                vel_reg[cmd.axis] <= clamp_pos(wr_val);
            if (wr_en && cmd.uop.dst == DST_POS)
                pos_reg[cmd.axis] <= clamp_pos(wr_val);
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cam_reg[0] <= cam_x;
            cam_reg[1] <= cam_y;
            cam_reg[2] <= cam_z;
            ft_reg     <= frame_time;
            d2_reg     <= '0;
        end
        if (wr_en)
        begin
            case (cmd.uop.dst)
                DST_OMEGA: omega_reg <= wr_val;
                DST_X:     x_reg     <= wr_val;
                DST_X2:    x2_reg    <= wr_val;
                DST_X3:    x3_reg    <= wr_val;
                DST_T1:    t1_reg    <= wr_val;
                DST_T2:    t2_reg    <= wr_val;
                DST_DEN:   den_reg   <= wr_val;
                DST_E:     e_reg     <= wr_val;
                DST_CH:    ch_reg    <= wr_val;
                DST_TMP:   tmp_reg   <= wr_val;
                DST_T:     t_reg     <= wr_val;
                DST_D2:    d2_reg    <= wr_val;
                DST_OX:    wx_reg    <= wr_val[OFS_W-1:0];
                DST_OY:    wy_reg    <= wr_val[OFS_W-1:0];
                default:   ;
            endcase
        end
        if (cmd.publish)
        begin
            offset_x_reg <= wx_reg;
            offset_y_reg <= wy_reg;
            snapped_reg  <= snap_reg;
        end
    end

    assign stat.done     = mul_done || div_done;
    assign stat.enable   = en_reg;
    assign stat.first    = first_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign offset_x  = offset_x_reg;
    assign offset_y  = offset_y_reg;
    assign snapped   = snapped_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ssgo_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssgo_ctrl
// Sequencer: steps the micro-programme, loops over the axes, hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module ssgo_ctrl
    import ssgo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    pc_t        pc_reg, pc_next;
    axis_t      axis_reg, axis_next;

    uop_t       uop;
    logic       multi;
    pc_t        adv_pc;
    axis_t      adv_axis;
    logic       adv_end;

    assign uop   = ucode(pc_reg);
    assign multi = (uop.op == OP_MUL) || (uop.op == OP_DIV) || (uop.op == OP_MOD);

    // Next micro-instruction
    always_comb
    begin
        adv_pc   = pc_reg + 5'd1;
        adv_axis = axis_reg;
        adv_end  = 1'b0;
        if (pc_reg == PC_AXIS_END && axis_reg != AXIS_LAST)
        begin
            adv_pc   = PC_AXIS;
            adv_axis = axis_reg + 2'd1;
        end
        else if (pc_reg == PC_INIT)
            adv_pc = PC_WRAPX;
        else if (pc_reg == PC_WRAPY)
            adv_end = 1'b1;
    end

    // State machine
    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        axis_next   = axis_reg;
        cmd.issue   = 1'b0;
        cmd.capture = 1'b0;
        cmd.publish = 1'b0;
        cmd.axis    = axis_reg;
        cmd.uop     = uop;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = '0;
                    pc_next     = (!stat.enable || stat.first) ? PC_INIT : '0;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (multi)
                    state_next = ST_WAIT;
                else
                begin
                    pc_next    = adv_pc;
                    axis_next  = adv_axis;
                    state_next = adv_end ? ST_DONE : ST_ISSUE;
                end
            end
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    pc_next    = adv_pc;
                    axis_next  = adv_axis;
                    state_next = adv_end ? ST_DONE : ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/spring_smoothed_grid_offset_unit.sv -----
// ----------------------------------------------------------------------------
// spring_smoothed_grid_offset_unit
// Critically damped spring smoother of the camera position, grid wrapped.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall) carries one frame per transaction:
//  cam_x/y/z and frame_time. Output channel (out_valid/out_stall) returns
//  offset_x, offset_y and snapped for every frame, in order.
//  Configuration is a plain write port (cfg_we, cfg_index, cfg_data) to be
//  used while the block is idle.
//  The work of a frame falls mostly on the shared restoring divider, used
//  four times with smoothing on and twice when the camera passes straight
//  through (smoothing off or first frame), and on the shared multiplier
//  (four 32x32 partial products per product).
//  One frame is in work at a time; in_stall stays high until its result has
//  been placed in the output register, and a new frame is taken while that
//  result still waits. A stalled result holds until out_stall falls; the
//  next frame then waits at its hand-off.
//  Reset clears the spring state, sets the first-frame flag and restores
//  the register defaults; no output is valid after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_smoothed_grid_offset_unit
    import ssgo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire reg_idx_t          cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire pos_t              cam_x,
    input  wire pos_t              cam_y,
    input  wire pos_t              cam_z,
    input  wire logic [FT_W-1:0]   frame_time,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [OFS_W-1:0]       offset_x,
    output logic [OFS_W-1:0]       offset_y,
    output logic                   snapped
);

    cmd_t  cmd;
    stat_t stat;

    ssgo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssgo_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cam_x      (cam_x),
        .cam_y      (cam_y),
        .cam_z      (cam_z),
        .frame_time (frame_time),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .snapped    (snapped)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ssgo_checker.sv -----
// ----------------------------------------------------------------------------
// ssgo_checker
// Port-level checks of the grid offset smoother.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ssgo_checker
    import ssgo_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [OFS_W-1:0]  offset_x,
    input wire logic [OFS_W-1:0]  offset_y,
    input wire logic              snapped
);

    // Nothing is offered while reset is held
    `SSGO_ASSERT_RST(a_no_valid_in_reset, !rst_n |-> !out_valid, "out_valid during reset")

    // One frame in work at a time: an accepted transaction closes the input
    `SSGO_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "input reopened at once")

    // A stalled result stays offered
    `SSGO_ASSERT(a_hold_valid, out_valid && out_stall |=> out_valid, "result dropped under stall")

    // A stalled result keeps its payload
    `SSGO_ASSERT(a_hold_data, out_valid && out_stall |=> $stable({offset_x, offset_y, snapped}), "payload changed under stall")

endmodule

bind spring_smoothed_grid_offset_unit ssgo_checker u_ssgo_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the spring-smoothed grid offset unit frame by frame against a
// bit-accurate predictor of the spring update, teleport snap and wrap, or
// typed values, over a directed table and constrained random camera paths.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import ssgo_pkg::*;

    localparam int  SETTLE_CYCLES = 400;
    localparam int  WATCHDOG_MAX  = 20000;
    localparam int  HOLD_CYCLES   = 3000;
    localparam int  RAND_PHASES   = 16;
    localparam int  PHASE_FRAMES  = 120;
    localparam int  DIR_ROWS      = 20;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    reg_idx_t          cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    pos_t              cam_x;
    pos_t              cam_y;
    pos_t              cam_z;
    logic [FT_W-1:0]   frame_time;
    logic              out_valid;
    logic              out_stall;
    logic [OFS_W-1:0]  offset_x;
    logic [OFS_W-1:0]  offset_y;
    logic              snapped;

    typedef struct {
        logic [OFS_W-1:0] ox;
        logic [OFS_W-1:0] oy;
        logic             snap;
    } offset_t;

    typedef struct {
        int               cfg_set;
        pos_t             cx;
        pos_t             cy;
        pos_t             cz;
        logic [FT_W-1:0]  ft;
        logic             typed;
        logic [OFS_W-1:0] ox;
        logic [OFS_W-1:0] oy;
        logic             snap;
    } frame_row_t;

    typedef struct {
        logic              en;
        logic [CFG_W-1:0]  st;
        logic [CFG_W-1:0]  sp;
        logic [ME_W-1:0]   me;
    } grid_cfg_t;

    offset_t      offset_q[$];
    int           errors;
    int           idle_cycles;
    logic         hold_req;
    logic         in_fire;
    logic         out_fire;

    // predictor copy of registers and spring state
    grid_cfg_t    cur_cfg;
    longint       spring_pos[3];
    longint       spring_vel[3];
    logic         first_pending;

    spring_smoothed_grid_offset_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cam_x      (cam_x),
        .cam_y      (cam_y),
        .cam_z      (cam_z),
        .frame_time (frame_time),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .snapped    (snapped)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // ------------------------------------------------------------------
    // Arithmetic of the spring, 64-bit words saturated to +-LIM
    // ------------------------------------------------------------------
    function automatic longint sat_sum(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > LIM)
            return LIM;
        if (s < -LIM)
            return -LIM;
        return s;
    endfunction

    // product shifted right, toward zero, saturated
    function automatic longint mul_shift(input longint a, input longint b, input int sh);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [127:0] r;
        longint       q;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 64'(-a) : 64'(a);
        ub   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        r    = prod >> sh;
        if (r > 128'(LIM))
            q = LIM;
        else
            q = longint'(r[63:0]);
        return neg ? -q : q;
    endfunction

    function automatic longint clamp48(input longint v);
        if (v > P_MAX)
            return P_MAX;
        if (v < P_MIN)
            return P_MIN;
        return v;
    endfunction

    function automatic logic [OFS_W-1:0] grid_wrap(input longint p, input longint period);
        longint r;
        r = p % period;
        if (r < 0)
            r += period;
        return r[OFS_W-1:0];
    endfunction

    // one frame through the spring, returns the wrapped offset
    function automatic offset_t smooth_frame(input pos_t cx, input pos_t cy, input pos_t cz,
                                             input logic [FT_W-1:0] ft);
        longint            cam[3];
        longint            omega, x, x2, x3, den, e, d2, ch, tmp, nv, np, d, period;
        longint            ftl;
        logic [CFG_W-1:0]  st;
        logic [CFG_W-1:0]  sp;
        logic [ME_W-1:0]   me;
        offset_t           res;
        cam[0] = longint'(cx);
        cam[1] = longint'(cy);
        cam[2] = longint'(cz);
        ftl    = longint'({48'd0, ft});
        res.snap = 1'b0;
        if (!cur_cfg.en || first_pending)
        begin
            for (int i = 0; i < 3; i++)
            begin
                spring_pos[i] = cam[i];
                spring_vel[i] = 0;
            end
            first_pending = !cur_cfg.en;
        end
        else
        begin
            st    = (cur_cfg.st < MIN_ST) ? MIN_ST : cur_cfg.st;
            omega = longint'((64'd2 << (2 * FRAC_BITS)) / {32'd0, st});
            x     = mul_shift(omega, ftl, DT_BITS);
            x2    = mul_shift(x, x, FRAC_BITS);
            x3    = mul_shift(x2, x, FRAC_BITS);
            den   = sat_sum(sat_sum(ONE_Q, x),
                            sat_sum(mul_shift(K1, x2, FRAC_BITS), mul_shift(K2, x3, FRAC_BITS)));
            e     = (64'sd1 <<< (2 * FRAC_BITS)) / den;
            d2    = 0;
            for (int i = 0; i < 3; i++)
            begin
                ch  = spring_pos[i] - cam[i];
                tmp = mul_shift(sat_sum(spring_vel[i], mul_shift(omega, ch, FRAC_BITS)),
                                ftl, DT_BITS);
                nv  = mul_shift(sat_sum(spring_vel[i], -mul_shift(omega, tmp, FRAC_BITS)),
                                e, FRAC_BITS);
                np  = sat_sum(cam[i], mul_shift(sat_sum(ch, tmp), e, FRAC_BITS));
                spring_vel[i] = clamp48(nv);
                spring_pos[i] = clamp48(np);
                d   = spring_pos[i] - cam[i];
                d2  = sat_sum(d2, mul_shift(d, d, FRAC_BITS));
            end
            // teleport snap
            if (d2 > THR2)
            begin
                res.snap = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    spring_pos[i] = cam[i];
                    spring_vel[i] = 0;
                end
            end
        end
        sp     = (cur_cfg.sp < MIN_SP) ? MIN_SP : cur_cfg.sp;
        me     = (cur_cfg.me == '0) ? ME_W'(1) : cur_cfg.me;
        period = longint'({32'd0, sp}) * longint'({48'd0, me});
        res.ox = grid_wrap(spring_pos[0], period);
        res.oy = grid_wrap(spring_pos[1], period);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
    endtask

    task automatic apply_cfg(input grid_cfg_t c);
        write_reg(REG_ENABLE, CFG_W'(c.en));
        write_reg(REG_STIME, c.st);
        write_reg(REG_SPACE, c.sp);
        write_reg(REG_MAJOR, CFG_W'(c.me));
        @(negedge clk);
        cfg_we  = 1'b0;
        cur_cfg = c;
    endtask

    // lower valid, let every frame come back, then let the block settle
    task automatic drain_frames();
        @(negedge clk);
        in_valid = 1'b0;
        while (offset_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input frame_row_t r);
        offset_t pred;
        @(negedge clk);
        in_valid   = 1'b1;
        cam_x      = r.cx;
        cam_y      = r.cy;
        cam_z      = r.cz;
        frame_time = r.ft;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = smooth_frame(r.cx, r.cy, r.cz, r.ft);
        if (r.typed)
        begin
            pred.ox   = r.ox;
            pred.oy   = r.oy;
            pred.snap = r.snap;
        end
        offset_q.insert(offset_q.size(), pred);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        offset_t want;
        if (rst_n && out_fire)
        begin
            if (offset_q.size() == 0)
            begin
                $display("%t: unexpected result x=%h y=%h snap=%b", $time,
                         offset_x, offset_y, snapped);
                errors++;
            end
            else
            begin
                want = offset_q.pop_front();
                if (want.ox !== offset_x)
                begin
                    $display("%t: offset_x expected %h actual %h", $time, want.ox, offset_x);
                    errors++;
                end
                if (want.oy !== offset_y)
                begin
                    $display("%t: offset_y expected %h actual %h", $time, want.oy, offset_y);
                    errors++;
                end
                if (want.snap !== snapped)
                begin
                    $display("%t: snapped expected %b actual %b", $time, want.snap, snapped);
                    errors++;
                end
            end
        end
    end

    // watchdog on transactions
    always @(posedge clk)
    begin
        if (!rst_n || in_fire || out_fire || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall patterns, with one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int len;
        int k;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                hold_req  = 1'b0;
            end
            mode = $urandom_range(0, 2);
            len  = $urandom_range(20, 300);
            k    = $urandom_range(2, 9);
            for (int i = 0; i < len; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 3) == 0);
                    default: out_stall = ((i % k) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    localparam longint UNIT = 64'sd1 <<< FRAC_BITS;

    initial
    begin
        grid_cfg_t   dir_cfg[4];
        frame_row_t  table_rows[DIR_ROWS];
        frame_row_t  r;
        grid_cfg_t   c;
        int          cur_set;
        int          burst;
        longint      px, py, pz;
        int          sel;

        errors        = 0;
        idle_cycles   = 0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ENABLE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        cam_x         = '0;
        cam_y         = '0;
        cam_z         = '0;
        frame_time    = '0;
        cur_cfg       = '{1'b0, RST_ST, RST_SP, RST_ME};
        first_pending = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            spring_pos[i] = 0;
            spring_vel[i] = 0;
        end

        // directed settings: reset defaults, smoothing on, floors, widest period
        dir_cfg[0] = '{1'b0, RST_ST, RST_SP, RST_ME};
        dir_cfg[1] = '{1'b1, RST_ST, RST_SP, RST_ME};
        dir_cfg[2] = '{1'b1, '0, '0, '0};
        dir_cfg[3] = '{1'b1, '1, '1, '1};

        // after reset: pass-through, period 10.0
        table_rows[0]  = '{0, '0, '0, '0, '0, 1, 47'd0, 47'd0, 0};
        table_rows[1]  = '{0, {1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}}, {1'b0, {47{1'b1}}},
                           16'hFFFF, 1, 47'd524287, 47'd524287, 0};
        table_rows[2]  = '{0, {1'b1, 47'd0}, {1'b1, 47'd0}, {1'b1, 47'd0},
                           16'd0, 1, 47'd131072, 47'd131072, 0};
        table_rows[3]  = '{0, '1, '1, '1, 16'd1, 1, 47'd655359, 47'd655359, 0};
        table_rows[4]  = '{0, 48'd1966085, 48'd7, 48'd3, 16'd100, 1, 47'd5, 47'd7, 0};
        // smoothing on: first frame, small step, zero and full frame time, teleport
        table_rows[5]  = '{1, 48'(5 * UNIT), 48'(-3 * UNIT), 48'(UNIT), 16'd1092, 0, 0, 0, 0};
        table_rows[6]  = '{1, 48'(6 * UNIT), 48'(-2 * UNIT), 48'(UNIT), 16'd1092, 0, 0, 0, 0};
        table_rows[7]  = '{1, 48'(7 * UNIT), 48'(-2 * UNIT), 48'(UNIT), 16'd0, 0, 0, 0, 0};
        table_rows[8]  = '{1, 48'(8 * UNIT), 48'(-1 * UNIT), 48'(UNIT), 16'hFFFF, 0, 0, 0, 0};
        table_rows[9]  = '{1, 48'(2000 * UNIT), 48'(0), 48'(UNIT), 16'd1092, 0, 0, 0, 0};
        table_rows[10] = '{1, 48'(2000 * UNIT), 48'(900 * UNIT), 48'(0), 16'd1092, 0, 0, 0, 0};
        table_rows[11] = '{1, {1'b0, {47{1'b1}}}, {1'b1, 47'd0}, {1'b0, {47{1'b1}}},
                           16'd30000, 0, 0, 0, 0};
        table_rows[12] = '{1, {1'b1, 47'd0}, {1'b0, {47{1'b1}}}, {1'b1, 47'd0},
                           16'hFFFF, 0, 0, 0, 0};
        // tiny time constant and spacing, zero major count
        table_rows[13] = '{2, 48'(UNIT), 48'(UNIT), 48'(UNIT), 16'd500, 0, 0, 0, 0};
        table_rows[14] = '{2, 48'(3 * UNIT), 48'(-UNIT), 48'(UNIT), 16'd500, 0, 0, 0, 0};
        table_rows[15] = '{2, 48'(4 * UNIT), 48'(-2 * UNIT), 48'(UNIT), 16'hFFFF, 0, 0, 0, 0};
        table_rows[16] = '{2, 48'(-7), 48'(9), 48'(0), 16'd1, 0, 0, 0, 0};
        // huge time constant, period beyond 47 bits
        table_rows[17] = '{3, 48'(-5 * UNIT), 48'(12 * UNIT), 48'(0), 16'd1092, 0, 0, 0, 0};
        table_rows[18] = '{3, 48'(-500 * UNIT), 48'(700 * UNIT), 48'(0), 16'hFFFF, 0, 0, 0, 0};
        table_rows[19] = '{3, {1'b1, 47'd0}, {1'b0, {47{1'b1}}}, '1, 16'd1092, 0, 0, 0, 0};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        cur_set = 0;
        foreach (table_rows[i])
        begin
            if (table_rows[i].cfg_set != cur_set)
            begin
                drain_frames();
                cur_set = table_rows[i].cfg_set;
                apply_cfg(dir_cfg[cur_set]);
            end
            send_frame(table_rows[i]);
        end

        // random phases
        px = 0;
        py = 0;
        pz = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_frames();
            case (ph % 4)
                0: c = '{1'($urandom), $urandom, $urandom, 16'($urandom)};
                1: c = '{1'b1, CFG_W'($urandom_range(0, 131072)),
                        CFG_W'($urandom_range(1, 262144)), ME_W'($urandom_range(0, 20))};
                2: c = '{1'b1, ($urandom_range(0, 1) ? CFG_W'(0) : '1),
                        ($urandom_range(0, 1) ? CFG_W'(0) : '1),
                        ($urandom_range(0, 1) ? ME_W'(0) : '1)};
                default: c = '{1'b0, CFG_W'($urandom_range(0, 65536)), RST_SP, RST_ME};
            endcase
            apply_cfg(c);
            if (ph == 5)
                hold_req = 1'b1;
            burst = $urandom_range(1, 12);
            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                sel = $urandom_range(0, 99);
                r.typed = 1'b0;
                r.ft    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 3000));
                if (sel < 72)
                begin
                    // smooth camera path
                    px += longint'($signed($urandom_range(0, 2097152))) - 1048576;
                    py += longint'($signed($urandom_range(0, 2097152))) - 1048576;
                    pz += longint'($signed($urandom_range(0, 65536))) - 32768;
                end
                else if (sel < 82)
                begin
                    // jump far enough to trip the snap
                    px += ($urandom_range(0, 1) ? 1 : -1) * 1500 * UNIT;
                    py += longint'($urandom_range(0, 800)) * UNIT;
                end
                else if (sel < 94)
                begin
                    px = longint'($signed({$urandom, $urandom})) >>> 16;
                    py = longint'($signed({$urandom, $urandom})) >>> 16;
                    pz = longint'($signed({$urandom, $urandom})) >>> 16;
                end
                else
                begin
                    px = $urandom_range(0, 1) ? P_MAX : P_MIN;
                    py = $urandom_range(0, 1) ? P_MAX : P_MIN;
                    pz = $urandom_range(0, 1) ? P_MAX : P_MIN;
                end
                r.cx = pos_t'(px);
                r.cy = pos_t'(py);
                r.cz = pos_t'(pz);
                px   = longint'(r.cx);
                py   = longint'(r.cy);
                pz   = longint'(r.cz);
                send_frame(r);
                // bursts with random gaps
                burst--;
                if (burst == 0)
                begin
                    @(negedge clk);
                    in_valid = 1'b0;
                    repeat ($urandom_range(0, 8)) @(negedge clk);
                    burst = $urandom_range(1, 12);
                end
            end
        end

        drain_frames();
        if (errors == 0 && offset_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
